@@ src/vmrt_pkg.sv @@
// Shared types, codes and constants for the memory and register transfer block.
`timescale 1ns / 1ps

package vmrt_pkg;

    localparam int MEM_DEPTH_DEF = 4096;
    localparam int FONT_ROWS_DEF = 5;
    localparam int FONT_BASE_DEF = 0;

    localparam int NUM_REGS  = 16;
    localparam int REG_IDX_W = 4;
    localparam int DATA_W    = 8;
    localparam int IDX_W     = 16;

    localparam logic [DATA_W-1:0] MAX_HEX_DIGIT = 8'h0F;

    typedef enum logic [2:0] {
        OP_MEM_WR = 3'd0,
        OP_MEM_RD = 3'd1,
        OP_REG_WR = 3'd2,
        OP_REG_RD = 3'd3,
        OP_IDX_WR = 3'd4,
        OP_GLYPH  = 3'd5,
        OP_STORE  = 3'd6,
        OP_LOAD   = 3'd7
    } op_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_BAD_DIGIT = 2'd1,
        ST_RANGE     = 2'd2
    } status_t;

    // One access to the machine memory; only the low address bits are used.
    typedef struct packed {
        logic              wr;
        logic              rd;
        logic [IDX_W-1:0]  addr;
        logic [DATA_W-1:0] wdata;
    } mem_req_t;

    // Write port of the general register file.
    typedef struct packed {
        logic                 we;
        logic [REG_IDX_W-1:0] waddr;
        logic [DATA_W-1:0]    wdata;
    } reg_wr_t;

endpackage

@@ src/vmrt_mem.sv @@
// Single-port machine memory with registered read data.
`timescale 1ns / 1ps

module vmrt_mem
    import vmrt_pkg::*;
#(
    parameter int MEM_DEPTH = MEM_DEPTH_DEF
)
(
    input  logic              clk,
    input  mem_req_t          req,
    output logic [DATA_W-1:0] rdata
);

    localparam int ADDR_W = $clog2(MEM_DEPTH);

    logic [DATA_W-1:0] mem [MEM_DEPTH];

    always_ff @(posedge clk)
    begin
        if (req.wr)
        begin
            mem[req.addr[ADDR_W-1:0]] <= req.wdata;
        end
        if (req.rd)
        begin
            rdata <= mem[req.addr[ADDR_W-1:0]];
        end
    end

endmodule

@@ src/vmrt_regfile.sv @@
// General register file and index register.
`timescale 1ns / 1ps

module vmrt_regfile
    import vmrt_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  reg_wr_t              wr,
    input  logic [REG_IDX_W-1:0] raddr,
    output logic [DATA_W-1:0]    rdata,
    input  logic                 idx_we,
    input  logic [IDX_W-1:0]     idx_wdata,
    output logic [IDX_W-1:0]     idx
);

    logic [DATA_W-1:0] regs_reg [NUM_REGS];
    logic [IDX_W-1:0]  idx_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_REGS; i++)
            begin
                regs_reg[i] <= '0;
            end
            idx_reg <= '0;
        end
        else
        begin
            if (wr.we)
            begin
                regs_reg[wr.waddr] <= wr.wdata;
            end
            if (idx_we)
            begin
                idx_reg <= idx_wdata;
            end
        end
    end

    assign rdata = regs_reg[raddr];
    assign idx   = idx_reg;

endmodule

@@ src/vmrt_agu.sv @@
// Shared address unit: adds base and offset and checks the sum against the memory size.
`timescale 1ns / 1ps

module vmrt_agu
    import vmrt_pkg::*;
#(
    parameter int MEM_DEPTH = MEM_DEPTH_DEF
)
(
    input  logic [IDX_W-1:0] base,
    input  logic [IDX_W-1:0] offset,
    output logic [IDX_W-1:0] sum,
    output logic             in_range
);

    localparam logic [IDX_W:0] Depth = (IDX_W+1)'(MEM_DEPTH);

    logic [IDX_W:0] full_sum;

    assign full_sum = {1'b0, base} + {1'b0, offset};
    assign sum      = full_sum[IDX_W-1:0];
    assign in_range = full_sum < Depth;

endmodule

@@ src/vm_memory_register_transfer_top.sv @@
// Top level: operation sequencer around the memory, register file and address unit.
//
// Usage: an operation is taken when start is high and busy is low. Its result
// appears on read_data, index_value and status for exactly one cycle with done
// high; the receiver cannot hold results off, so it must take every beat. An
// operation keeps the block busy while in S_EXEC, and a rejected one ends there;
// an in-range memory read also passes S_RDWAIT; an in-range store moves
// registers 0 to X in S_XFER, and an in-range load does so, then waits in S_LWAIT,
// where X is the last register moved. The single memory port moves one byte per cycle.
// A new operation may be started in the cycle its predecessor's result is shown.
// After reset the block stays busy while it clears memory.
`timescale 1ns / 1ps

module vm_memory_register_transfer_top
    import vmrt_pkg::*;
#(
    parameter int MEM_DEPTH = MEM_DEPTH_DEF,
    parameter int FONT_ROWS = FONT_ROWS_DEF,
    parameter int FONT_BASE = FONT_BASE_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic [2:0]           op,
    input  logic [IDX_W-1:0]     addr,
    input  logic [REG_IDX_W-1:0] reg_index,
    input  logic [DATA_W-1:0]    data,
    output logic                 done,
    output logic [DATA_W-1:0]    read_data,
    output logic [IDX_W-1:0]     index_value,
    output logic [1:0]           status
);

    localparam int ADDR_W = $clog2(MEM_DEPTH);
    localparam logic [ADDR_W-1:0] LastAddr  = ADDR_W'(MEM_DEPTH - 1);
    localparam logic [IDX_W-1:0]  FontBase  = IDX_W'(FONT_BASE);
    localparam logic [IDX_W-1:0]  FontRows  = IDX_W'(FONT_ROWS);

    typedef enum logic [5:0] {
        S_CLEAR  = 6'b000001,
        S_IDLE   = 6'b000010,
        S_EXEC   = 6'b000100,
        S_RDWAIT = 6'b001000,
        S_XFER   = 6'b010000,
        S_LWAIT  = 6'b100000
    } state_t;

    state_t state_reg, state_next;
    logic [ADDR_W-1:0]    clr_reg, clr_next;
    logic [REG_IDX_W-1:0] k_reg, k_next;
    logic                 pend_reg, pend_next;
    logic [REG_IDX_W-1:0] pend_idx_reg, pend_idx_next;
    logic                 done_reg, done_next;

    op_t                  op_reg;
    logic [IDX_W-1:0]     addr_reg;
    logic [REG_IDX_W-1:0] rx_reg;
    logic [DATA_W-1:0]    data_reg;

    logic [DATA_W-1:0]    read_data_reg, read_data_next;
    logic [IDX_W-1:0]     index_value_reg, index_value_next;
    status_t              status_reg, status_next;

    mem_req_t             mem_req;
    logic [DATA_W-1:0]    mem_rdata;
    reg_wr_t              rf_wr;
    logic [REG_IDX_W-1:0] rf_raddr;
    logic [DATA_W-1:0]    rf_rdata;
    logic                 idx_we;
    logic [IDX_W-1:0]     idx_wdata;
    logic [IDX_W-1:0]     idx;
    logic [IDX_W-1:0]     agu_base, agu_offset, agu_sum;
    logic                 agu_in_range;
    logic [IDX_W-1:0]     glyph_idx;
    logic                 accept;

    vmrt_mem #(
        .MEM_DEPTH(MEM_DEPTH)
    ) u_mem (
        .clk  (clk),
        .req  (mem_req),
        .rdata(mem_rdata)
    );

    vmrt_regfile u_regfile (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr       (rf_wr),
        .raddr    (rf_raddr),
        .rdata    (rf_rdata),
        .idx_we   (idx_we),
        .idx_wdata(idx_wdata),
        .idx      (idx)
    );

    vmrt_agu #(
        .MEM_DEPTH(MEM_DEPTH)
    ) u_agu (
        .base    (agu_base),
        .offset  (agu_offset),
        .sum     (agu_sum),
        .in_range(agu_in_range)
    );

    assign accept    = start && (state_reg == S_IDLE);
    assign rf_raddr  = (state_reg == S_XFER) ? k_reg : rx_reg;
    assign glyph_idx = FontBase + IDX_W'(rf_rdata[REG_IDX_W-1:0]) * FontRows;

    always_comb
    begin
        state_next       = state_reg;
        clr_next         = clr_reg;
        k_next           = k_reg;
        pend_next        = 1'b0;
        pend_idx_next    = pend_idx_reg;
        done_next        = 1'b0;
        read_data_next   = read_data_reg;
        index_value_next = index_value_reg;
        status_next      = status_reg;
        mem_req          = '0;
        rf_wr            = '0;
        idx_we           = 1'b0;
        idx_wdata        = addr_reg;
        agu_base         = addr_reg;
        agu_offset       = '0;

        // A load's read data lands in the cycle after its address was issued.
        if (pend_reg)
        begin
            rf_wr.we    = 1'b1;
            rf_wr.waddr = pend_idx_reg;
            rf_wr.wdata = mem_rdata;
        end

        unique case (state_reg)
            S_CLEAR:
            begin
                mem_req.wr   = 1'b1;
                mem_req.addr = IDX_W'(clr_reg);
                clr_next     = clr_reg + 1'b1;
                if (clr_reg == LastAddr)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                read_data_next   = '0;
                index_value_next = idx;
                status_next      = ST_OK;
                done_next        = 1'b1;
                state_next       = S_IDLE;
                unique case (op_reg) inside
                    OP_MEM_WR:
                    begin
                        if (agu_in_range)
                        begin
                            mem_req.wr    = 1'b1;
                            mem_req.addr  = agu_sum;
                            mem_req.wdata = data_reg;
                        end
                        else
                        begin
                            status_next = ST_RANGE;
                        end
                    end
                    OP_MEM_RD:
                    begin
                        if (agu_in_range)
                        begin
                            mem_req.rd = 1'b1;
                            mem_req.addr = agu_sum;
                            done_next  = 1'b0;
                            state_next = S_RDWAIT;
                        end
                        else
                        begin
                            status_next = ST_RANGE;
                        end
                    end
                    OP_REG_WR:
                    begin
                        rf_wr.we    = 1'b1;
                        rf_wr.waddr = rx_reg;
                        rf_wr.wdata = data_reg;
                    end
                    OP_REG_RD:
                    begin
                        read_data_next = rf_rdata;
                    end
                    OP_IDX_WR:
                    begin
                        idx_we           = 1'b1;
                        idx_wdata        = addr_reg;
                        index_value_next = addr_reg;
                    end
                    OP_GLYPH:
                    begin
                        if (rf_rdata > MAX_HEX_DIGIT)
                        begin
                            status_next = ST_BAD_DIGIT;
                        end
                        else
                        begin
                            idx_we           = 1'b1;
                            idx_wdata        = glyph_idx;
                            index_value_next = glyph_idx;
                        end
                    end
                    OP_STORE, OP_LOAD:
                    begin
                        agu_base   = idx;
                        agu_offset = IDX_W'(rx_reg);
                        if (agu_in_range)
                        begin
                            k_next     = '0;
                            done_next  = 1'b0;
                            state_next = S_XFER;
                        end
                        else
                        begin
                            status_next = ST_RANGE;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            S_RDWAIT:
            begin
                read_data_next = mem_rdata;
                done_next      = 1'b1;
                state_next     = S_IDLE;
            end
            S_XFER:
            begin
                agu_base     = idx;
                agu_offset   = IDX_W'(k_reg);
                mem_req.addr = agu_sum;
                if (op_reg == OP_STORE)
                begin
                    mem_req.wr    = 1'b1;
                    mem_req.wdata = rf_rdata;
                end
                else
                begin
                    mem_req.rd    = 1'b1;
                    pend_next     = 1'b1;
                    pend_idx_next = k_reg;
                end
                k_next = k_reg + 1'b1;
                if (k_reg == rx_reg)
                begin
                    if (op_reg == OP_STORE)
                    begin
                        done_next  = 1'b1;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        state_next = S_LWAIT;
                    end
                end
            end
            S_LWAIT:
            begin
                done_next  = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            clr_reg   <= '0;
            k_reg     <= '0;
            pend_reg  <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            k_reg     <= k_next;
            pend_reg  <= pend_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg   <= op_t'(op);
            addr_reg <= addr;
            rx_reg   <= reg_index;
            data_reg <= data;
        end
        pend_idx_reg    <= pend_idx_next;
        read_data_reg   <= read_data_next;
        index_value_reg <= index_value_next;
        status_reg      <= status_next;
    end

    assign busy        = (state_reg != S_IDLE);
    assign done        = done_reg;
    assign read_data   = read_data_reg;
    assign index_value = index_value_reg;
    assign status      = status_reg;

endmodule
